// ===== design/mcm_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mcm_pkg
// Shared widths, constants and register codes for the machine cycle monitor.
// -----------------------------------------------------------------------------
package mcm_pkg;

   localparam int MAX_REJECT_SENSORS = 8;
   localparam int LINE_COUNT         = 8;

   localparam int EDGE_TIMER_W  = 17;
   localparam int CYCLE_TIMER_W = 20;
   localparam int STOP_TIMER_W  = 17;
   localparam int RATE_W        = 23;
   localparam int COUNT_W       = 32;
   localparam int CFG_MS_W      = 16;
   localparam int CFG_SENS_W    = 4;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int DIV_STEP_W    = 5;

   localparam logic [EDGE_TIMER_W-1:0]  EDGE_TIMER_MAX  = '1;
   localparam logic [CYCLE_TIMER_W-1:0] CYCLE_TIMER_MAX = '1;
   localparam logic [STOP_TIMER_W-1:0]  STOP_TIMER_MAX  = '1;

   // cycles per minute x100 from a cycle time in ms
   localparam logic [RATE_W-1:0] RATE_NUMERATOR = 23'd6000000;

   localparam logic [CFG_MS_W-1:0]   DEBOUNCE_RESET     = 16'd50;
   localparam logic [CFG_MS_W-1:0]   STOP_TIMEOUT_RESET = 16'd3000;
   localparam logic [CFG_SENS_W-1:0] SENSOR_CNT_RESET   = 4'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_STOP_TIMEOUT = 2'd1,
      CSR_SENSOR_COUNT = 2'd2
   } csr_index_type;

endpackage

// ===== design/mcm_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mcm channel interfaces
// Valid/ready channels for tick words, result words and register writes.
// -----------------------------------------------------------------------------
interface mcm_req_if;
   logic       valid;
   logic       ready;
   logic       cycle_edge;
   logic [7:0] reject_lines;
   logic       clear_counts;

   modport source (output valid, output cycle_edge, output reject_lines,
                   output clear_counts, input ready);
   modport sink   (input valid, input cycle_edge, input reject_lines,
                   input clear_counts, output ready);
endinterface

interface mcm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               running;
   logic                               cycle_done;
   logic                               cycle_rejected;
   logic [mcm_pkg::CYCLE_TIMER_W-1:0]  cycle_ms;
   logic [mcm_pkg::RATE_W-1:0]         cpm_x100;
   logic [mcm_pkg::COUNT_W-1:0]        good_count;
   logic [mcm_pkg::COUNT_W-1:0]        reject_hits;

   modport source (output valid, output running, output cycle_done,
                   output cycle_rejected, output cycle_ms, output cpm_x100,
                   output good_count, output reject_hits, input ready);
   modport sink   (input valid, input running, input cycle_done,
                   input cycle_rejected, input cycle_ms, input cpm_x100,
                   input good_count, input reject_hits, output ready);
endinterface

interface mcm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mcm_pkg::CSR_INDEX_W-1:0]  index;
   logic [mcm_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/machine_cycle_monitor.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// machine_cycle_monitor
// Per-tick cycle timing, rate and good/reject counting for one machine.
// -----------------------------------------------------------------------------
//  channel  | dir | word
//  req_if   | in  | cycle_edge, reject_lines, clear_counts (one ms tick)
//  rsp_if   | out | running, cycle_done, cycle_rejected, cycle_ms, cpm_x100,
//           |     | good_count, reject_hits
//  csr_if   | in  | index, data (register write)
//
//  A tick that completes a cycle and stays running passes through the rate
//  divider (S_DIV), a restoring divider with one quotient bit per cycle over
//  23 bits; other ticks go straight to the output state (S_OUT).
//  req_if.ready is low from acceptance until the result is in the output
//  register; the output register lets a new tick in while a result waits.
//  Synchronous active-high reset returns the state, config, timer, count and
//  output-valid registers to their reset values. csr_if is always ready.
// -----------------------------------------------------------------------------
module machine_cycle_monitor (
   input  logic      clock,
   input  logic      reset,
   mcm_req_if.sink   req_if,
   mcm_rsp_if.source rsp_if,
   mcm_csr_if.sink   csr_if
);
   import mcm_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_type;

   state_type state_ff, state_in;

   logic [CFG_MS_W-1:0]   debounce_ff, stop_timeout_ff;
   logic [CFG_SENS_W-1:0] sensor_cnt_ff;

   logic [EDGE_TIMER_W-1:0]  sae_ff, sae_in;
   logic [CYCLE_TIMER_W-1:0] slc_ff, slc_in;
   logic [STOP_TIMER_W-1:0]  str_ff, str_in;
   logic                     armed_ff, armed_in;
   logic                     running_ff, running_in;
   logic [CYCLE_TIMER_W-1:0] cycle_ms_ff, cycle_ms_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;
   logic [COUNT_W-1:0]       good_ff, good_in;
   logic [COUNT_W-1:0]       rej_ff, rej_in;
   logic                     done_ff, done_in;
   logic                     rejected_ff, rejected_in;
   logic                     clear_ff, clear_in;

   logic [CYCLE_TIMER_W-1:0] div_d_ff, div_d_in;
   logic [CYCLE_TIMER_W:0]   div_rem_ff, div_rem_in;
   logic [RATE_W-1:0]        div_q_ff, div_q_in;
   logic [DIV_STEP_W-1:0]    div_step_ff, div_step_in;

   logic                     out_valid_ff, out_valid_in;
   logic                     out_running_ff, out_running_in;
   logic                     out_done_ff, out_done_in;
   logic                     out_rejected_ff, out_rejected_in;
   logic [CYCLE_TIMER_W-1:0] out_cycle_ms_ff, out_cycle_ms_in;
   logic [RATE_W-1:0]        out_rate_ff, out_rate_in;
   logic [COUNT_W-1:0]       out_good_ff, out_good_in;
   logic [COUNT_W-1:0]       out_rej_ff, out_rej_in;

   logic                     req_take;
   logic [EDGE_TIMER_W-1:0]  sae_b;
   logic [CYCLE_TIMER_W-1:0] slc_b;
   logic [STOP_TIMER_W-1:0]  str_b;
   logic                     edge_ok;
   logic [CFG_SENS_W-1:0]    n_lines;
   logic [CFG_SENS_W-1:0]    hits;
   logic [CYCLE_TIMER_W:0]   trial;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.running        = out_running_ff;
   assign rsp_if.cycle_done     = out_done_ff;
   assign rsp_if.cycle_rejected = out_rejected_ff;
   assign rsp_if.cycle_ms       = out_cycle_ms_ff;
   assign rsp_if.cpm_x100       = out_rate_ff;
   assign rsp_if.good_count     = out_good_ff;
   assign rsp_if.reject_hits    = out_rej_ff;

   // saturating timer advance
   assign sae_b = (sae_ff < EDGE_TIMER_MAX)  ? sae_ff + 1'b1 : EDGE_TIMER_MAX;
   assign slc_b = (slc_ff < CYCLE_TIMER_MAX) ? slc_ff + 1'b1 : CYCLE_TIMER_MAX;
   assign str_b = (str_ff < STOP_TIMER_MAX)  ? str_ff + 1'b1 : STOP_TIMER_MAX;

   assign edge_ok = req_if.cycle_edge && (sae_b > {1'b0, debounce_ff});

   assign n_lines = (sensor_cnt_ff > CFG_SENS_W'(MAX_REJECT_SENSORS))
                  ? CFG_SENS_W'(MAX_REJECT_SENSORS) : sensor_cnt_ff;

   always_comb begin
      hits = '0;
      for (int i = 0; i < LINE_COUNT; i++) begin
         if ((CFG_SENS_W'(i) < n_lines) && !req_if.reject_lines[i]) begin
            hits = hits + 1'b1;
         end
      end
   end

   assign trial = {div_rem_ff[CYCLE_TIMER_W-1:0], RATE_NUMERATOR[div_step_ff]};

   always_comb begin
      state_in        = state_ff;
      sae_in          = sae_ff;
      slc_in          = slc_ff;
      str_in          = str_ff;
      armed_in        = armed_ff;
      running_in      = running_ff;
      cycle_ms_in     = cycle_ms_ff;
      rate_in         = rate_ff;
      good_in         = good_ff;
      rej_in          = rej_ff;
      done_in         = done_ff;
      rejected_in     = rejected_ff;
      clear_in        = clear_ff;
      div_d_in        = div_d_ff;
      div_rem_in      = div_rem_ff;
      div_q_in        = div_q_ff;
      div_step_in     = div_step_ff;
      out_valid_in    = out_valid_ff && !rsp_if.ready;
      out_running_in  = out_running_ff;
      out_done_in     = out_done_ff;
      out_rejected_in = out_rejected_ff;
      out_cycle_ms_in = out_cycle_ms_ff;
      out_rate_in     = out_rate_ff;
      out_good_in     = out_good_ff;
      out_rej_in      = out_rej_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               logic cyc;
               logic stop;
               logic run_n;
               logic [STOP_TIMER_W-1:0] str_n;
               cyc         = edge_ok && armed_ff;
               sae_in      = edge_ok ? '0 : sae_b;
               slc_in      = edge_ok ? '0 : slc_b;
               str_n       = cyc ? '0 : str_b;
               run_n       = cyc || running_ff;
               stop        = run_n && (str_n >= {1'b0, stop_timeout_ff});
               str_in      = str_n;
               running_in  = run_n && !stop;
               armed_in    = (edge_ok || armed_ff) && !stop;
               cycle_ms_in = stop ? '0 : (cyc ? slc_b : cycle_ms_ff);
               if (stop) begin
                  rate_in = '0;
               end
               done_in     = cyc;
               rejected_in = cyc && (hits != '0);
               if (cyc) begin
                  rej_in = rej_ff + COUNT_W'(hits);
                  if (hits == '0) begin
                     good_in = good_ff + 1'b1;
                  end
               end
               clear_in    = req_if.clear_counts;
               div_d_in    = slc_b;
               div_rem_in  = '0;
               div_q_in    = '0;
               div_step_in = DIV_STEP_W'(RATE_W - 1);
               state_in    = (cyc && !stop) ? S_DIV : S_OUT;
            end
         end
         S_DIV: begin
            if (trial >= {1'b0, div_d_ff}) begin
               div_rem_in = trial - {1'b0, div_d_ff};
               div_q_in   = {div_q_ff[RATE_W-2:0], 1'b1};
            end else begin
               div_rem_in = trial;
               div_q_in   = {div_q_ff[RATE_W-2:0], 1'b0};
            end
            div_step_in = div_step_ff - 1'b1;
            if (div_step_ff == '0) begin
               rate_in  = div_q_in;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_if.ready) begin
               out_valid_in    = 1'b1;
               out_running_in  = running_ff;
               out_done_in     = done_ff;
               out_rejected_in = rejected_ff;
               out_cycle_ms_in = cycle_ms_ff;
               out_rate_in     = rate_ff;
               out_good_in     = good_ff;
               out_rej_in      = rej_ff;
               if (clear_ff) begin
                  good_in = '0;
                  rej_in  = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         debounce_ff     <= DEBOUNCE_RESET;
         stop_timeout_ff <= STOP_TIMEOUT_RESET;
         sensor_cnt_ff   <= SENSOR_CNT_RESET;
         sae_ff          <= EDGE_TIMER_MAX;
         slc_ff          <= '0;
         str_ff          <= '0;
         armed_ff        <= 1'b0;
         running_ff      <= 1'b0;
         cycle_ms_ff     <= '0;
         rate_ff         <= '0;
         good_ff         <= '0;
         rej_ff          <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sae_ff       <= sae_in;
         slc_ff       <= slc_in;
         str_ff       <= str_in;
         armed_ff     <= armed_in;
         running_ff   <= running_in;
         cycle_ms_ff  <= cycle_ms_in;
         rate_ff      <= rate_in;
         good_ff      <= good_in;
         rej_ff       <= rej_in;
         out_valid_ff <= out_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            unique case (csr_index_type'(csr_if.index))
               CSR_DEBOUNCE:     debounce_ff     <= csr_if.data;
               CSR_STOP_TIMEOUT: stop_timeout_ff <= csr_if.data;
               CSR_SENSOR_COUNT: sensor_cnt_ff   <= csr_if.data[CFG_SENS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      done_ff         <= done_in;
      rejected_ff     <= rejected_in;
      clear_ff        <= clear_in;
      div_d_ff        <= div_d_in;
      div_rem_ff      <= div_rem_in;
      div_q_ff        <= div_q_in;
      div_step_ff     <= div_step_in;
      out_running_ff  <= out_running_in;
      out_done_ff     <= out_done_in;
      out_rejected_ff <= out_rejected_in;
      out_cycle_ms_ff <= out_cycle_ms_in;
      out_rate_ff     <= out_rate_in;
      out_good_ff     <= out_good_in;
      out_rej_ff      <= out_rej_in;
   end

   a_one_word_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("tick word taken while another is in progress");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_d_ff != '0))
      else $error("rate divider started with zero cycle time");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) && (div_step_ff != DIV_STEP_W'(RATE_W - 1))
      |-> (div_rem_ff < {1'b0, div_d_ff}))
      else $error("divider remainder out of range");

   a_stopped_zeroed: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_running_ff) |-> (out_cycle_ms_ff == '0) && (out_rate_ff == '0))
      else $error("stopped result carries a cycle time or rate");

   a_reject_implies_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) && out_rejected_ff |-> out_done_ff)
      else $error("rejected flag without a completed cycle");

endmodule
